// File: rtl/rfvq_pkg.sv
`timescale 1ns / 1ps
package rfvq_pkg;

	// Fixed field widths of the request and result ports.
	localparam int VAL_W   = 32;
	localparam int IDX_W   = 12;
	localparam int COUNT_W = 13;

	// Request operation codes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Result status codes.
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FWD_RD,
		ST_FWD_WR,
		ST_BWD_RD,
		ST_BWD_WR,
		ST_TREE_RD,
		ST_TREE_WR,
		ST_Q_RD_L,
		ST_Q_RD_R,
		ST_Q_EVAL,
		ST_Q_WALK,
		ST_Q_ACC
	} rfvq_state_t;

endpackage

// File: rtl/rfvq_max.sv
`timescale 1ns / 1ps
// Shared maximum unit: largest of a base value and two optionally enabled values.
module rfvq_max #(
	parameter int W = 13
) (
	input  logic [W-1:0] base,
	input  logic [W-1:0] x,
	input  logic         x_en,
	input  logic [W-1:0] y,
	input  logic         y_en,
	output logic [W-1:0] result
);

	logic [W-1:0] xm;
	logic [W-1:0] ym;
	logic [W-1:0] xy;

	// Disabled operands count as zero.
	always_comb begin
		xm     = x_en ? x : '0;
		ym     = y_en ? y : '0;
		xy     = (xm >= ym) ? xm : ym;
		result = (base >= xy) ? base : xy;
	end

endmodule

// File: rtl/range_frequent_value_query_unit.sv
`timescale 1ns / 1ps
// Range frequent-value query unit.
// A request is taken at a rising edge where start is high and busy is low.
// operation selects a load (element, final_element) or a query
// (left_index, right_index). A load gives no result.
// A load marked final_element closes the sequence of n elements and builds
// the run tables and the max tree: a forward and a backward pass over the
// elements and a pass over the tree nodes, one read then one write per step.
// A query gives one result, shown for one cycle with done high: a bad or
// early query in the cycle after the request, a good one after the states
// Q_RD_L, Q_RD_R and Q_EVAL when no tree walk is needed, else after those,
// a Q_WALK and Q_ACC pair for each tree level walked and a final Q_WALK.
// The tree walk, one level per Q_WALK and Q_ACC pair through the tree memory's two read
// ports, sets the query time. busy stays high until the result is shown.
// Reset clears the sequence and the built flag; memories keep no reset.
// The receiver cannot stall: results are taken in their one cycle.
module range_frequent_value_query_unit #(
	parameter int MAX_LEN = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic signed [rfvq_pkg::VAL_W-1:0]   element,
	input  logic                                final_element,
	input  logic [rfvq_pkg::IDX_W-1:0]          left_index,
	input  logic [rfvq_pkg::IDX_W-1:0]          right_index,
	output logic                                done,
	output logic [rfvq_pkg::COUNT_W-1:0]        most_count,
	output logic                                status
);

	import rfvq_pkg::*;

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int IW = $clog2(2 * MAX_LEN);
	localparam int TW = $clog2(2 * MAX_LEN + 1);
	localparam int EW = (CW > IDX_W) ? CW : IDX_W;

	// Memories.
	logic [VAL_W-1:0] val_mem  [MAX_LEN];
	logic [AW-1:0]    beg_mem  [MAX_LEN];
	logic [CW-1:0]    size_mem [MAX_LEN];
	logic [CW-1:0]    tree_mem [2 * MAX_LEN];

	logic [VAL_W-1:0] val_rd_q;
	logic [AW-1:0]    beg_rd_q;
	logic [CW-1:0]    size_rd_q;
	logic [CW-1:0]    tra_q;
	logic [CW-1:0]    trb_q;

	rfvq_state_t state_q, state_d;

	logic [CW-1:0]    n_q;
	logic             ready_q;
	logic [AW-1:0]    k_q;
	logic [VAL_W-1:0] prev_val_q;
	logic [AW-1:0]    prev_beg_q;
	logic [AW-1:0]    end_q;
	logic [AW-1:0]    l_q;
	logic [AW-1:0]    r_q;
	logic [VAL_W-1:0] vl_q;
	logic [AW-1:0]    bl_q;
	logic [CW-1:0]    sl_q;
	logic [CW-1:0]    best_q;
	logic [TW-1:0]    a_q;
	logic [TW-1:0]    b_q;
	logic             fa_q;
	logic             fb_q;
	logic             done_q;
	logic [COUNT_W-1:0] count_q;
	logic             status_q;

	logic             accept;
	logic             q_err;
	logic [AW-1:0]    last_idx;
	logic [AW-1:0]    rd_addr;
	logic [IW-1:0]    tra_addr;
	logic [IW-1:0]    trb_addr;
	logic             tree_we;
	logic [IW-1:0]    tree_wa;
	logic [CW-1:0]    tree_wd;
	logic [AW-1:0]    new_beg;
	logic [AW-1:0]    end_now;
	logic [CW-1:0]    run_len;
	logic             c0_ok;
	logic             c1_ok;
	logic [TW-1:0]    leaf_lim;
	logic             vals_eq;
	logic [CW-1:0]    span;
	logic [CW-1:0]    left_end;
	logic [CW-1:0]    left_part;
	logic [CW-1:0]    right_part;
	logic             do_walk;
	logic [CW-1:0]    mx_base;
	logic [CW-1:0]    mx_x;
	logic             mx_x_en;
	logic [CW-1:0]    mx_y;
	logic             mx_y_en;
	logic [CW-1:0]    mx_out;
	logic [TW-1:0]    b_dec;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign last_idx = AW'(n_q - CW'(1));
	assign q_err    = !ready_q || (left_index > right_index)
		|| (EW'(right_index) >= EW'(n_q));

	// Shared maximum unit.
	rfvq_max #(.W(CW)) u_max (
		.base   (mx_base),
		.x      (mx_x),
		.x_en   (mx_x_en),
		.y      (mx_y),
		.y_en   (mx_y_en),
		.result (mx_out)
	);

	// Datapath arithmetic for the build passes and the query evaluation.
	always_comb begin
		new_beg    = ((k_q == '0) || (val_rd_q != prev_val_q)) ? k_q : prev_beg_q;
		end_now    = ((k_q == last_idx) || ({1'b0, prev_beg_q} == ({1'b0, k_q} + 1'b1)))
			? k_q : end_q;
		run_len    = CW'(end_now) - CW'(beg_rd_q) + CW'(1);
		leaf_lim   = TW'(MAX_LEN) + TW'(n_q);
		c0_ok      = TW'({k_q, 1'b0}) < leaf_lim;
		c1_ok      = TW'({k_q, 1'b1}) < leaf_lim;
		vals_eq    = (vl_q == val_rd_q);
		span       = CW'(r_q) - CW'(l_q) + CW'(1);
		left_end   = CW'(bl_q) + sl_q;
		left_part  = left_end - CW'(l_q);
		right_part = CW'(r_q) - CW'(beg_rd_q) + CW'(1);
		do_walk    = left_end < CW'(beg_rd_q);
		b_dec      = b_q - TW'(1);
	end

	// Next state, memory addressing and operand selection.
	always_comb begin
		state_d  = state_q;
		rd_addr  = k_q;
		tra_addr = IW'({k_q, 1'b0});
		trb_addr = IW'({k_q, 1'b1});
		tree_we  = 1'b0;
		tree_wa  = IW'(k_q);
		tree_wd  = run_len;
		mx_base  = '0;
		mx_x     = tra_q;
		mx_x_en  = c0_ok;
		mx_y     = trb_q;
		mx_y_en  = c1_ok;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_LOAD) begin
						if (final_element) begin
							state_d = ST_FWD_RD;
						end
					end else if (!q_err) begin
						state_d = ST_Q_RD_L;
					end
				end
			end
			ST_FWD_RD: begin
				state_d = ST_FWD_WR;
			end
			ST_FWD_WR: begin
				state_d = (k_q == last_idx) ? ST_BWD_RD : ST_FWD_RD;
			end
			ST_BWD_RD: begin
				state_d = ST_BWD_WR;
			end
			ST_BWD_WR: begin
				tree_we = 1'b1;
				tree_wa = IW'(MAX_LEN) + IW'(k_q);
				state_d = (k_q == '0) ? ST_TREE_RD : ST_BWD_RD;
			end
			ST_TREE_RD: begin
				state_d = ST_TREE_WR;
			end
			ST_TREE_WR: begin
				tree_we = 1'b1;
				tree_wd = mx_out;
				state_d = (k_q == AW'(1)) ? ST_IDLE : ST_TREE_RD;
			end
			ST_Q_RD_L: begin
				rd_addr = l_q;
				state_d = ST_Q_RD_R;
			end
			ST_Q_RD_R: begin
				rd_addr = r_q;
				state_d = ST_Q_EVAL;
			end
			ST_Q_EVAL: begin
				mx_x    = left_part;
				mx_x_en = 1'b1;
				mx_y    = right_part;
				mx_y_en = 1'b1;
				state_d = (!vals_eq && do_walk) ? ST_Q_WALK : ST_IDLE;
			end
			ST_Q_WALK: begin
				tra_addr = a_q[IW-1:0];
				trb_addr = b_dec[IW-1:0];
				state_d  = (a_q < b_q) ? ST_Q_ACC : ST_IDLE;
			end
			ST_Q_ACC: begin
				mx_base = best_q;
				mx_x_en = fa_q;
				mx_y_en = fb_q;
				state_d = ST_Q_WALK;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: sequence length, built flag and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			ready_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept && (operation == OP_LOAD)) begin
				if (ready_q) begin
					ready_q <= 1'b0;
					n_q     <= CW'(1);
				end else if (n_q < CW'(MAX_LEN)) begin
					n_q <= n_q + CW'(1);
				end
			end
			if (state_q == ST_TREE_WR && k_q == AW'(1)) begin
				ready_q <= 1'b1;
			end
			if (accept && (operation == OP_QUERY) && q_err) begin
				done_q <= 1'b1;
			end
			if (state_q == ST_Q_EVAL && (vals_eq || !do_walk)) begin
				done_q <= 1'b1;
			end
			if (state_q == ST_Q_WALK && !(a_q < b_q)) begin
				done_q <= 1'b1;
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				k_q      <= '0;
				l_q      <= AW'(left_index);
				r_q      <= AW'(right_index);
				count_q  <= '0;
				status_q <= STATUS_ERR;
			end
			ST_FWD_WR: begin
				prev_val_q <= val_rd_q;
				prev_beg_q <= new_beg;
				if (k_q != last_idx) begin
					k_q <= k_q + AW'(1);
				end
			end
			ST_BWD_WR: begin
				prev_beg_q <= beg_rd_q;
				end_q      <= end_now;
				if (k_q == '0) begin
					k_q <= AW'(MAX_LEN - 1);
				end else begin
					k_q <= k_q - AW'(1);
				end
			end
			ST_TREE_WR: begin
				k_q <= k_q - AW'(1);
			end
			ST_Q_RD_R: begin
				vl_q <= val_rd_q;
				bl_q <= beg_rd_q;
				sl_q <= size_rd_q;
			end
			ST_Q_EVAL: begin
				best_q   <= vals_eq ? span : mx_out;
				count_q  <= COUNT_W'(vals_eq ? span : mx_out);
				status_q <= STATUS_OK;
				a_q      <= TW'(left_end) + TW'(MAX_LEN);
				b_q      <= TW'(beg_rd_q) + TW'(MAX_LEN);
			end
			ST_Q_WALK: begin
				fa_q    <= a_q[0];
				fb_q    <= b_q[0];
				a_q     <= (a_q + TW'(a_q[0])) >> 1;
				b_q     <= (b_q - TW'(b_q[0])) >> 1;
				count_q <= COUNT_W'(best_q);
			end
			ST_Q_ACC: begin
				best_q <= mx_out;
			end
			default: begin
			end
		endcase
	end

	// Value store: load writes, registered read.
	always_ff @(posedge clk) begin
		if (accept && (operation == OP_LOAD) && (ready_q || (n_q < CW'(MAX_LEN)))) begin
			val_mem[ready_q ? '0 : n_q[AW-1:0]] <= element;
		end
		val_rd_q <= val_mem[rd_addr];
	end

	// Run start table.
	always_ff @(posedge clk) begin
		if (state_q == ST_FWD_WR) begin
			beg_mem[k_q] <= new_beg;
		end
		beg_rd_q <= beg_mem[rd_addr];
	end

	// Run length table.
	always_ff @(posedge clk) begin
		if (state_q == ST_BWD_WR) begin
			size_mem[k_q] <= run_len;
		end
		size_rd_q <= size_mem[rd_addr];
	end

	// Max tree: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (tree_we) begin
			tree_mem[tree_wa] <= tree_wd;
		end
		tra_q <= tree_mem[tra_addr];
		trb_q <= tree_mem[trb_addr];
	end

	assign done       = done_q;
	assign most_count = count_q;
	assign status     = status_q;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import rfvq_pkg::*;

	localparam int LEN       = 4096;
	localparam int LIMIT     = 3000000;

	// One request as the driver presents it.
	typedef struct {
		logic                    op;
		logic signed [VAL_W-1:0] elem;
		logic                    fin;
		logic [IDX_W-1:0]        lidx;
		logic [IDX_W-1:0]        ridx;
		bit                      drain_first;
	} request_t;

	// One expected query answer.
	typedef struct {
		logic [COUNT_W-1:0] cnt;
		logic               st;
	} answer_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic                    operation = OP_LOAD;
	logic signed [VAL_W-1:0] element = '0;
	logic                    final_element = 1'b0;
	logic [IDX_W-1:0]        left_index = '0;
	logic [IDX_W-1:0]        right_index = '0;
	logic                    done;
	logic [COUNT_W-1:0]      most_count;
	logic                    status;

	request_t pending_reqs[$];
	answer_t  answers_due[$];
	int       mismatches = 0;
	int       accepted = 0;
	int       gap_pct = 28;
	int       cycle_cnt = 0;

	// Shadow copy of the block's sequence, run tables and max tree.
	logic [VAL_W-1:0] seq_vals[LEN];
	int               run_start[LEN];
	int               run_len[LEN];
	int               run_tree[2*LEN];
	int               seq_len = 0;
	bit               built = 0;

	range_frequent_value_query_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .element(element), .final_element(final_element),
		.left_index(left_index), .right_index(right_index),
		.done(done), .most_count(most_count), .status(status)
	);

	always #2 clk = ~clk;

	// Find equal-value runs and build the max tree over run lengths.
	function automatic void build_runs();
		int i;
		int j;
		i = 0;
		while (i < seq_len) begin
			j = i;
			while (j + 1 < seq_len && seq_vals[j+1] == seq_vals[i])
				j++;
			for (int k = i; k <= j; k++) begin
				run_start[k] = i;
				run_len[k] = j - i + 1;
			end
			i = j + 1;
		end
		for (int k = 0; k < LEN; k++)
			run_tree[LEN+k] = (k < seq_len) ? run_len[k] : 0;
		for (int k = LEN - 1; k >= 1; k--)
			run_tree[k] = (run_tree[2*k] >= run_tree[2*k+1]) ? run_tree[2*k] : run_tree[2*k+1];
		built = 1;
	endfunction

	// Largest run length over positions lo..hi.
	function automatic int span_max(int lo, int hi);
		int best;
		int a;
		int b;
		best = 0;
		a = lo + LEN;
		b = hi + LEN + 1;
		while (a < b) begin
			if (a[0]) begin
				if (run_tree[a] > best) best = run_tree[a];
				a++;
			end
			if (b[0]) begin
				b--;
				if (run_tree[b] > best) best = run_tree[b];
			end
			a = a >> 1;
			b = b >> 1;
		end
		return best;
	endfunction

	// Apply one accepted request to the shadow state; queue the answer of a query.
	function automatic void apply_request(request_t rq);
		answer_t ans;
		int l;
		int r;
		int lend;
		int best;
		if (rq.op == OP_LOAD) begin
			if (built) begin
				seq_len = 0;
				built = 0;
			end
			if (seq_len < LEN) begin
				seq_vals[seq_len] = rq.elem;
				seq_len++;
			end
			if (rq.fin) build_runs();
			return;
		end
		l = rq.lidx;
		r = rq.ridx;
		if (!built || l > r || r >= seq_len) begin
			ans.cnt = '0;
			ans.st = STATUS_ERR;
		end else begin
			if (seq_vals[l] == seq_vals[r]) begin
				best = r - l + 1;
			end else begin
				lend = run_start[l] + run_len[l];
				best = lend - l;
				if (r - run_start[r] + 1 > best) best = r - run_start[r] + 1;
				if (run_start[r] >= 1 && lend <= run_start[r] - 1)
					if (span_max(lend, run_start[r] - 1) > best)
						best = span_max(lend, run_start[r] - 1);
			end
			ans.cnt = best[COUNT_W-1:0];
			ans.st = STATUS_OK;
		end
		answers_due.push_back(ans);
	endfunction

	// Request driver: presents queued requests with random gaps.
	always @(posedge clk or negedge arst_n) begin
		request_t rq;
		bit       took;
		bit       gap;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			took = start && !busy;
			if (took) begin
				apply_request('{operation, element, final_element, left_index,
					right_index, 1'b0});
				accepted++;
			end
			if (!start || !busy) begin
				gap = ($urandom_range(99) < gap_pct);
				if (pending_reqs.size() == 0 || gap ||
					(pending_reqs[0].drain_first &&
					(took || busy || answers_due.size() != 0))) begin
					start <= 1'b0;
				end else begin
					rq = pending_reqs.pop_front();
					operation <= rq.op;
					element <= rq.elem;
					final_element <= rq.fin;
					left_index <= rq.lidx;
					right_index <= rq.ridx;
					start <= 1'b1;
				end
			end
		end
	end

	// Result monitor: compares each strobed result with the oldest answer due.
	always @(posedge clk) begin
		answer_t ans;
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: most_count=%0d status=%0d",
						most_count, status);
			end else begin
				ans = answers_due.pop_front();
				if (most_count !== ans.cnt || status !== ans.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected most_count=%0d status=%0d, got %0d %0d",
							ans.cnt, ans.st, most_count, status);
				end
			end
		end
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic void add_load(logic signed [VAL_W-1:0] v, logic fin);
		pending_reqs.push_back('{OP_LOAD, v, fin, '0, '0, 1'b0});
	endfunction

	function automatic void add_query(int l, int r, bit drain);
		pending_reqs.push_back('{OP_QUERY, $urandom, 1'b0, l[IDX_W-1:0],
			r[IDX_W-1:0], drain});
	endfunction

	// Non-decreasing sequence of n values with random repeats, then queries.
	function automatic void add_sorted_set(int n, int nq);
		longint v;
		longint nx;
		int     l;
		v = $signed($urandom);
		for (int i = 0; i < n; i++) begin
			add_load(v[VAL_W-1:0], i == n - 1);
			if ($urandom_range(99) < 45) begin
				nx = v + $urandom_range(1, 3);
				if (nx <= 64'sd2147483647) v = nx;
			end
		end
		for (int q = 0; q < nq; q++) begin
			if ($urandom_range(99) < 85) begin
				l = $urandom_range(0, n - 1);
				add_query(l, $urandom_range(l, n - 1), q == 0 && $urandom_range(99) < 20);
			end else begin
				add_query($urandom_range(4095), $urandom_range(4095), 1'b0);
			end
		end
	endfunction

	initial begin
		int n;
		// Directed: query before any build, extremes, single element, unsorted input.
		add_query(0, 0, 1'b0);
		add_load(32'sh80000000, 1'b0);
		add_load(32'sh80000000, 1'b0);
		add_load(0, 1'b0);
		add_load(5, 1'b0);
		add_load(5, 1'b0);
		add_load(5, 1'b0);
		add_load(32'sh7fffffff, 1'b1);
		add_query(0, 6, 1'b1);
		add_query(0, 1, 1'b0);
		add_query(3, 5, 1'b0);
		add_query(1, 3, 1'b0);
		add_query(5, 2, 1'b0);
		add_query(0, 7, 1'b0);
		add_query(4095, 4095, 1'b0);
		add_load(9, 1'b1);
		add_query(0, 0, 1'b0);
		add_query(0, 1, 1'b0);
		add_load(3, 1'b0);
		add_load(1, 1'b0);
		add_load(1, 1'b0);
		add_load(3, 1'b1);
		add_query(0, 3, 1'b0);
		add_load(4, 1'b0);
		add_query(0, 0, 1'b1);
		// Random: mostly short sorted sets, some unsorted noise.
		while (pending_reqs.size() < 400) begin
			n = $urandom_range(1, 24);
			if ($urandom_range(99) < 10) begin
				for (int i = 0; i < n; i++)
					add_load($urandom_range(3), i == n - 1);
				add_query(0, n - 1, 1'b0);
				add_query($urandom_range(n - 1), n - 1, 1'b0);
			end else begin
				add_sorted_set(n, $urandom_range(6, 14));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_reqs.size() != 0 || start) begin
			@(posedge clk);
			if (accepted > 280) gap_pct = 0;
			else if (accepted > 140) gap_pct = 54;
		end
		while (answers_due.size() != 0 || busy) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
